FILE: hw/rtl/msg_pkg.sv
// Shared types, constants and widths for the multi-stop RGB gradient.
`timescale 1ns / 1ps
`default_nettype none
package msg_pkg;

	localparam int POS_W      = 16;
	localparam int CNT_W      = 3;
	localparam int COLOR_W    = 24;
	localparam int CH_W       = 8;
	localparam int REG_IDX_W  = 3;
	localparam int MAX_STOPS  = 6;
	localparam int IDX_W      = 3;
	localparam int PCT_W      = 7;
	localparam int PCT_SCALE  = 100;
	// percent dividend: frac * 100 with frac below 2^16
	localparam int DVD_W      = 23;
	localparam int MAG_W      = PCT_W + CH_W;

	// register indexes
	localparam logic [REG_IDX_W-1:0] REG_RESOLUTION = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_COUNT      = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_COLOR0     = 3'd2;

	// reciprocals for constant division of a 16-bit value
	localparam int DIV3_MUL     = 43691;
	localparam int DIV3_SHIFT   = 17;
	localparam int DIV5_MUL     = 52429;
	localparam int DIV5_SHIFT   = 18;
	localparam int DIV100_MUL   = 5243;
	localparam int DIV100_SHIFT = 19;

	typedef struct packed {
		logic [POS_W-1:0]                      resolution;
		logic [CNT_W-1:0]                      color_count;
		logic [MAX_STOPS-1:0][COLOR_W-1:0]     palette;
	} cfg_t;

	// segment stage result: percent dividend and divisor
	typedef struct packed {
		logic [DVD_W-1:0] dividend;
		logic [POS_W-1:0] seglen;
		logic [IDX_W-1:0] idx;
		logic             blank;
		logic             single;
	} seg_t;

	// percent stage result
	typedef struct packed {
		logic [PCT_W-1:0] pct;
		logic [IDX_W-1:0] idx;
		logic             blank;
		logic             single;
	} pct_t;

endpackage
`default_nettype wire

FILE: hw/rtl/msg_if.sv
// Stream and configuration interfaces of the multi-stop RGB gradient.
`timescale 1ns / 1ps
`default_nettype none
interface msg_pos_if;
	import msg_pkg::*;
	logic             valid;
	logic             ready;
	logic [POS_W-1:0] position;
	modport source (output valid, output position, input ready);
	modport sink   (input valid, input position, output ready);
endinterface

interface msg_rgb_if;
	import msg_pkg::*;
	logic            valid;
	logic            ready;
	logic [CH_W-1:0] red;
	logic [CH_W-1:0] green;
	logic [CH_W-1:0] blue;
	logic            blank;
	modport source (output valid, output red, output green, output blue, output blank,
		input ready);
	modport sink   (input valid, input red, input green, input blue, input blank,
		output ready);
endinterface

interface msg_cfg_if;
	import msg_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [REG_IDX_W-1:0] index;
	logic [COLOR_W-1:0]   data;
	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/msg_cfg.sv
// Configuration register file of the multi-stop RGB gradient.
`timescale 1ns / 1ps
`default_nettype none
module msg_cfg (
	input  wire logic           clk,
	input  wire logic           arst_n,
	msg_cfg_if.sink             cfg,
	output msg_pkg::cfg_t       regs
);
	import msg_pkg::*;

	cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q <= '0;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_RESOLUTION: regs_q.resolution  <= cfg.data[POS_W-1:0];
				REG_COUNT:      regs_q.color_count <= cfg.data[CNT_W-1:0];
				default: begin
					// remaining indexes map onto the palette stops
					regs_q.palette[3'(cfg.index - REG_COLOR0)] <= cfg.data;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

FILE: hw/rtl/msg_seg.sv
// Segment length, segment index and percent dividend, two pipeline stages.
`timescale 1ns / 1ps
`default_nettype none
module msg_seg (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire msg_pkg::cfg_t          regs,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire logic [msg_pkg::POS_W-1:0] in_pos,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output msg_pkg::seg_t               out_seg
);
	import msg_pkg::*;

	logic             v_s1, v_s2;
	logic             en_s1, en_s2;
	logic [POS_W-1:0] pos_s1, seglen_s1;
	logic [CNT_W-1:0] cnt_s1;
	logic             blank_s1, single_s1;
	seg_t             seg_s2;

	logic [CNT_W-1:0] cnt_sat;
	logic [POS_W-1:0] seglen;
	logic [31:0]      p3, p5;
	logic [18:0]      mult [0:5];
	logic [IDX_W-1:0] idx;
	logic [POS_W-1:0] frac;
	seg_t             seg_d;

	assign en_s2     = !v_s2 || out_ready;
	assign en_s1     = !v_s1 || en_s2;
	assign in_ready  = en_s1;
	assign out_valid = v_s2;
	assign out_seg   = seg_s2;

	// stage 1: saturate the count and divide the resolution by count - 1
	always_comb begin
		cnt_sat = (regs.color_count > CNT_W'(MAX_STOPS)) ? CNT_W'(MAX_STOPS)
			: regs.color_count;
		p3 = 32'(regs.resolution) * 32'(DIV3_MUL);
		p5 = 32'(regs.resolution) * 32'(DIV5_MUL);
		case (cnt_sat)
			3'd2:    seglen = regs.resolution;
			3'd3:    seglen = regs.resolution >> 1;
			3'd4:    seglen = POS_W'(p3 >> DIV3_SHIFT);
			3'd5:    seglen = regs.resolution >> 2;
			3'd6:    seglen = POS_W'(p5 >> DIV5_SHIFT);
			default: seglen = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en_s1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			pos_s1    <= in_pos;
			seglen_s1 <= seglen;
			cnt_s1    <= cnt_sat;
			blank_s1  <= (cnt_sat == '0) || (regs.resolution == '0)
				|| (in_pos >= regs.resolution);
			single_s1 <= (cnt_sat == 3'd1);
		end
	end

	// stage 2: segment index by compare against multiples, then remainder
	always_comb begin
		idx = '0;
		mult[0] = '0;
		for (int k = 1; k <= 5; k++) begin
			mult[k] = 19'(k) * 19'(seglen_s1);
			idx = idx + IDX_W'({3'b000, pos_s1} >= mult[k]);
		end
		frac = pos_s1 - POS_W'(mult[idx]);
		seg_d.dividend = DVD_W'(frac) * DVD_W'(PCT_SCALE);
		seg_d.seglen   = seglen_s1;
		seg_d.idx      = idx;
		seg_d.single   = single_s1 && !blank_s1;
		seg_d.blank    = blank_s1 || (!single_s1
			&& ((seglen_s1 == '0) || ((4'(idx) + 4'd1) >= 4'(cnt_s1))));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2 && v_s1) begin
			seg_s2 <= seg_d;
		end
	end

endmodule
`default_nettype wire

FILE: hw/rtl/msg_div.sv
// Restoring percent divider, 2+2+2+1 quotient bits over four stages.
`timescale 1ns / 1ps
`default_nettype none
module msg_div (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire msg_pkg::seg_t in_seg,
	output logic               out_valid,
	input  wire logic          out_ready,
	output msg_pkg::pct_t      out_pct
);
	import msg_pkg::*;

	typedef struct packed {
		logic             hit;
		logic [DVD_W-1:0] rem;
	} step_t;

	function automatic step_t div_step(input logic [DVD_W-1:0] rem,
		input logic [POS_W-1:0] den, input int sh);
		step_t            r;
		logic [DVD_W-1:0] d;
		d = DVD_W'(den) << sh;
		r.hit = (rem >= d);
		r.rem = r.hit ? (rem - d) : rem;
		return r;
	endfunction

	logic             v_s3, v_s4, v_s5, v_s6;
	logic             en_s3, en_s4, en_s5, en_s6;
	seg_t             seg_s3, seg_s4, seg_s5;
	logic [PCT_W-1:0] q_s3, q_s4, q_s5;
	pct_t             pct_s6;

	step_t a3, b3, a4, b4, a5, b5, a6;
	seg_t  nx3, nx4, nx5;

	assign en_s6     = !v_s6 || out_ready;
	assign en_s5     = !v_s5 || en_s6;
	assign en_s4     = !v_s4 || en_s5;
	assign en_s3     = !v_s3 || en_s4;
	assign in_ready  = en_s3;
	assign out_valid = v_s6;
	assign out_pct   = pct_s6;

	// dividend field carries the partial remainder from stage to stage
	always_comb begin
		a3 = div_step(in_seg.dividend, in_seg.seglen, 6);
		b3 = div_step(a3.rem, in_seg.seglen, 5);
		a4 = div_step(seg_s3.dividend, seg_s3.seglen, 4);
		b4 = div_step(a4.rem, seg_s3.seglen, 3);
		a5 = div_step(seg_s4.dividend, seg_s4.seglen, 2);
		b5 = div_step(a5.rem, seg_s4.seglen, 1);
		a6 = div_step(seg_s5.dividend, seg_s5.seglen, 0);
		nx3          = in_seg;
		nx3.dividend = b3.rem;
		nx4          = seg_s3;
		nx4.dividend = b4.rem;
		nx5          = seg_s4;
		nx5.dividend = b5.rem;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en_s3) v_s3 <= in_valid;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
			if (en_s6) v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3 && in_valid) begin
			seg_s3 <= nx3;
			q_s3   <= {a3.hit, b3.hit, 5'b00000};
		end
		if (en_s4 && v_s3) begin
			seg_s4 <= nx4;
			q_s4   <= {q_s3[6:5], a4.hit, b4.hit, 3'b000};
		end
		if (en_s5 && v_s4) begin
			seg_s5 <= nx5;
			q_s5   <= {q_s4[6:3], a5.hit, b5.hit, 1'b0};
		end
		if (en_s6 && v_s5) begin
			pct_s6.pct    <= {q_s5[6:1], a6.hit};
			pct_s6.idx    <= seg_s5.idx;
			pct_s6.blank  <= seg_s5.blank;
			pct_s6.single <= seg_s5.single;
		end
	end

endmodule
`default_nettype wire

FILE: hw/rtl/msg_blend.sv
// Channel blend: percent times stop difference, divided by 100 toward zero.
`timescale 1ns / 1ps
`default_nettype none
module msg_blend (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire msg_pkg::cfg_t regs,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire msg_pkg::pct_t in_pct,
	msg_rgb_if.source          color
);
	import msg_pkg::*;

	logic             v_s7, v_s8;
	logic             en_s7, en_s8;
	logic [CH_W-1:0]  from_s7 [0:2];
	logic [MAG_W-1:0] mag_s7 [0:2];
	logic             neg_s7 [0:2];
	logic             blank_s7;
	logic [CH_W-1:0]  ch_s8 [0:2];
	logic             blank_s8;

	logic [IDX_W-1:0] ia;
	logic [CH_W-1:0]  ca [0:2];
	logic [CH_W-1:0]  cb [0:2];
	logic [CH_W-1:0]  dmag [0:2];
	logic             dneg [0:2];
	logic [27:0]      qp [0:2];
	logic [CH_W-1:0]  q [0:2];

	assign en_s8       = !v_s8 || color.ready;
	assign en_s7       = !v_s7 || en_s8;
	assign in_ready    = en_s7;
	assign color.valid = v_s8;
	assign color.red   = ch_s8[0];
	assign color.green = ch_s8[1];
	assign color.blue  = ch_s8[2];
	assign color.blank = blank_s8;

	// stage 7: pick the two stops, take the difference apart into sign and size
	always_comb begin
		ia = (in_pct.idx > IDX_W'(MAX_STOPS - 2)) ? IDX_W'(MAX_STOPS - 2) : in_pct.idx;
		for (int c = 0; c < 3; c++) begin
			ca[c]   = regs.palette[ia][COLOR_W-1-CH_W*c -: CH_W];
			cb[c]   = regs.palette[3'(ia + 3'd1)][COLOR_W-1-CH_W*c -: CH_W];
			dneg[c] = (cb[c] < ca[c]);
			dmag[c] = dneg[c] ? (ca[c] - cb[c]) : (cb[c] - ca[c]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else begin
			if (en_s7) v_s7 <= in_valid;
			if (en_s8) v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s7 && in_valid) begin
			blank_s7 <= in_pct.blank;
			for (int c = 0; c < 3; c++) begin
				neg_s7[c] <= dneg[c];
				if (in_pct.blank) begin
					from_s7[c] <= '0;
					mag_s7[c]  <= '0;
				end else if (in_pct.single) begin
					from_s7[c] <= regs.palette[0][COLOR_W-1-CH_W*c -: CH_W];
					mag_s7[c]  <= '0;
				end else begin
					from_s7[c] <= ca[c];
					mag_s7[c]  <= MAG_W'(in_pct.pct) * MAG_W'(dmag[c]);
				end
			end
		end
	end

	// stage 8: divide the size by 100 through its reciprocal, apply the sign
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			qp[c] = 28'(mag_s7[c]) * 28'(DIV100_MUL);
			q[c]  = CH_W'(qp[c] >> DIV100_SHIFT);
		end
	end

	always_ff @(posedge clk) begin
		if (en_s8 && v_s7) begin
			blank_s8 <= blank_s7;
			for (int c = 0; c < 3; c++) begin
				ch_s8[c] <= neg_s7[c] ? (from_s7[c] - q[c]) : (from_s7[c] + q[c]);
			end
		end
	end

endmodule
`default_nettype wire

FILE: hw/rtl/multi_stop_rgb_gradient.sv
// Top level of the multi-stop RGB gradient: position in, blended RGB word out.
//
//   channel  dir   word                         handshake
//   cfg      in    index[2:0], data[23:0]       valid / ready (ready held high)
//   pos      in    position[15:0]               valid / ready
//   color    out   red, green, blue, blank      valid / ready
//
// Rate: one word per cycle sustained while the output is ready.
//   The pipeline has eight stages: two for segment lookup,
//   four for the percent divider, two for the blend.
// Reset: arst_n clears the configuration registers and every stage valid.
// Stalls: each stage holds its word while the next stage is full and cannot move on;
//   bubbles close up, so new positions are taken while a result waits at the output and a stage is free.
`timescale 1ns / 1ps
`default_nettype none
module multi_stop_rgb_gradient (
	input  wire logic clk,
	input  wire logic arst_n,
	msg_cfg_if.sink   cfg,
	msg_pos_if.sink   pos,
	msg_rgb_if.source color
);
	import msg_pkg::*;

	localparam int PIPE_DEPTH = 8;
	localparam int FLIGHT_W   = $clog2(PIPE_DEPTH + 1);

	cfg_t regs;

	// segment stage to divider
	logic seg_valid, seg_ready;
	seg_t seg_word;

	// divider to blend
	logic pct_valid, pct_ready;
	pct_t pct_word;

	// register file: the user must write it only while no word is in flight; the block does not enforce this
	msg_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	// guards, segment length, segment index and percent dividend
	msg_seg u_seg (
		.clk       (clk),
		.arst_n    (arst_n),
		.regs      (regs),
		.in_valid  (pos.valid),
		.in_ready  (pos.ready),
		.in_pos    (pos.position),
		.out_valid (seg_valid),
		.out_ready (seg_ready),
		.out_seg   (seg_word)
	);

	// percent within the segment, 0 to 99 unless the word is blank or single
	msg_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (seg_valid),
		.in_ready  (seg_ready),
		.in_seg    (seg_word),
		.out_valid (pct_valid),
		.out_ready (pct_ready),
		.out_pct   (pct_word)
	);

	// stop lookup and per-channel blend, drives the output register
	msg_blend u_blend (
		.clk      (clk),
		.arst_n   (arst_n),
		.regs     (regs),
		.in_valid (pct_valid),
		.in_ready (pct_ready),
		.in_pct   (pct_word),
		.color    (color)
	);

	// count words in flight for the checks below
	logic                acc_in, acc_out;
	logic [FLIGHT_W-1:0] flight_q;

	assign acc_in  = pos.valid && pos.ready;
	assign acc_out = color.valid && color.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flight_q <= '0;
		end else begin
			flight_q <= flight_q + FLIGHT_W'(acc_in) - FLIGHT_W'(acc_out);
		end
	end

	a_blank_black: assert property (@(posedge clk) disable iff (!arst_n)
		color.valid && color.blank |-> color.red == '0 && color.green == '0
			&& color.blue == '0)
		else $error("blank word carries a nonzero colour");

	a_flight_bound: assert property (@(posedge clk) disable iff (!arst_n)
		flight_q <= FLIGHT_W'(PIPE_DEPTH))
		else $error("more words in flight than pipeline stages");

	a_empty_no_out: assert property (@(posedge clk) disable iff (!arst_n)
		flight_q == '0 |-> !color.valid)
		else $error("result shown with no word in flight");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		flight_q == FLIGHT_W'(PIPE_DEPTH) && !color.ready |-> !pos.ready)
		else $error("full pipeline took a word while stalled");

endmodule
`default_nettype wire
